### rtl/lrfs_pkg.sv
// Shared types, constants and helpers for the LCD rectangle fill stream.
// Holds the item and result payloads, queue entry format and config codes.
// No dependencies.
package lrfs_pkg;

	// Geometry sizing
	localparam int MAX_SIDE = 1024;
	localparam int COORD_W = $clog2(MAX_SIDE);
	localparam int SIZE_W = $clog2(MAX_SIDE + 1);
	localparam int LEFT_W = $clog2(MAX_SIDE * MAX_SIDE + 1);
	localparam int IN_W = 12;
	localparam int WIDE_W = (SIZE_W > IN_W) ? SIZE_W : IN_W;
	localparam int BOUND_W = 16;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	// Configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_OFFSET = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_OFFSET = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_SET_OPCODE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_SET_OPCODE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_WRITE_OPCODE = 3'd6;

	localparam logic [10:0] RST_SCREEN_WIDTH = 11'd240;
	localparam logic [10:0] RST_SCREEN_HEIGHT = 11'd240;
	localparam logic [9:0] RST_COLUMN_OFFSET = 10'd0;
	localparam logic [9:0] RST_ROW_OFFSET = 10'd0;
	localparam logic [7:0] RST_COLUMN_SET_OPCODE = 8'h2A;
	localparam logic [7:0] RST_ROW_SET_OPCODE = 8'h2B;
	localparam logic [7:0] RST_MEMORY_WRITE_OPCODE = 8'h2C;

	typedef enum logic [1:0] {
		ACT_SOLID_START = 2'd0,
		ACT_IMAGE_START = 2'd1,
		ACT_PIXEL = 2'd2,
		ACT_TICK = 2'd3
	} action_t;

	typedef struct packed {
		action_t action;
		logic [11:0] rect_x;
		logic [11:0] rect_y;
		logic [11:0] rect_width;
		logic [11:0] rect_height;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic is_data;
		logic last;
	} result_t;

	typedef enum logic {
		KIND_START = 1'b0,
		KIND_PIXEL = 1'b1
	} kind_t;

	// One queued job: window bounds for a start, or a color in a for a pixel
	typedef struct packed {
		kind_t kind;
		logic [BOUND_W-1:0] a;
		logic [BOUND_W-1:0] b;
		logic [BOUND_W-1:0] c;
		logic [BOUND_W-1:0] d;
		logic last;
	} entry_t;

	typedef struct packed {
		logic [SIZE_W-1:0] screen_w;
		logic [SIZE_W-1:0] screen_h;
		logic [9:0] col_off;
		logic [9:0] row_off;
	} geom_t;

	typedef struct packed {
		logic [7:0] col_op;
		logic [7:0] row_op;
		logic [7:0] mem_op;
	} ops_t;

	// Map a raw screen size onto 1..MAX_SIDE
	function automatic logic [SIZE_W-1:0] eff_size(input logic [10:0] s);
		logic [SIZE_W-1:0] r;
		if (s == 11'd0) begin
			r = SIZE_W'(1);
		end else if (int'(s) > MAX_SIDE) begin
			r = SIZE_W'(MAX_SIDE);
		end else begin
			r = SIZE_W'(s);
		end
		return r;
	endfunction

	// RGB888 to RGB565: keep red & 0xF8, green & 0xFC, blue top five bits
	function automatic logic [15:0] to565(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

endpackage

### rtl/lrfs_queue.sv
// Short job queue between the fill front end and the byte emitter.
// Depends on lrfs_pkg for the entry type and depth.
module lrfs_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input lrfs_pkg::entry_t push_entry,
	input logic pop,
	output lrfs_pkg::entry_t head,
	output logic full,
	output logic empty
);
	import lrfs_pkg::*;

	entry_t mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0] count_q;

	assign full = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head = mem_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + (QPTR_W + 1)'(1);
				2'b01: count_q <= count_q - (QPTR_W + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/lrfs_front.sv
// Front end: accepts items, clamps rectangles, tracks the active fill and
// pushes start and pixel jobs into the queue. Depends on lrfs_pkg.
module lrfs_front (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input lrfs_pkg::item_t item,
	input lrfs_pkg::geom_t geom,
	input logic q_full,
	output logic push,
	output lrfs_pkg::entry_t push_entry
);
	import lrfs_pkg::*;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_SOLID,
		MODE_IMAGE
	} mode_t;

	mode_t mode_q;
	logic [15:0] color_q;
	logic [LEFT_W-1:0] left_q;

	logic valid_s1;
	action_t action_s1;
	logic [COORD_W-1:0] x_s1;
	logic [COORD_W-1:0] y_s1;
	logic [SIZE_W-1:0] w_s1;
	logic [SIZE_W-1:0] h_s1;
	logic [15:0] color_s1;

	logic [WIDE_W-1:0] xin_w, xmax_w, xc_w, xroom_w, win_w, wc_w;
	logic [WIDE_W-1:0] yin_w, ymax_w, yc_w, yroom_w, hin_w, hc_w;
	logic [2*SIZE_W-1:0] area;
	logic is_start, pix_ok, emits, adv, load;

	// Clamp origin and extent of the incoming rectangle
	always_comb begin
		xin_w = WIDE_W'(item.rect_x);
		xmax_w = WIDE_W'(geom.screen_w) - WIDE_W'(1);
		xc_w = (xin_w > xmax_w) ? xmax_w : xin_w;
		xroom_w = WIDE_W'(geom.screen_w) - xc_w;
		win_w = (item.rect_width == '0) ? WIDE_W'(1) : WIDE_W'(item.rect_width);
		wc_w = (win_w > xroom_w) ? xroom_w : win_w;

		yin_w = WIDE_W'(item.rect_y);
		ymax_w = WIDE_W'(geom.screen_h) - WIDE_W'(1);
		yc_w = (yin_w > ymax_w) ? ymax_w : yin_w;
		yroom_w = WIDE_W'(geom.screen_h) - yc_w;
		hin_w = (item.rect_height == '0) ? WIDE_W'(1) : WIDE_W'(item.rect_height);
		hc_w = (hin_w > yroom_w) ? yroom_w : hin_w;
	end

	// Classify the held item against the active fill
	always_comb begin
		is_start = (action_s1 == ACT_SOLID_START) || (action_s1 == ACT_IMAGE_START);
		pix_ok = (left_q != '0) &&
			(((action_s1 == ACT_PIXEL) && (mode_q == MODE_IMAGE)) ||
			((action_s1 == ACT_TICK) && (mode_q == MODE_SOLID)));
		emits = is_start || pix_ok;
		adv = valid_s1 && (!emits || !q_full);
		item_stall = valid_s1 && !adv;
		load = item_valid && !item_stall;
		push = adv && emits;
		area = w_s1 * h_s1;
	end

	// Build the queue entry
	always_comb begin
		push_entry = '0;
		if (is_start) begin
			push_entry.kind = KIND_START;
			push_entry.a = BOUND_W'(x_s1) + BOUND_W'(geom.col_off);
			push_entry.b = BOUND_W'(x_s1) + BOUND_W'(w_s1) - BOUND_W'(1) +
				BOUND_W'(geom.col_off);
			push_entry.c = BOUND_W'(y_s1) + BOUND_W'(geom.row_off);
			push_entry.d = BOUND_W'(y_s1) + BOUND_W'(h_s1) - BOUND_W'(1) +
				BOUND_W'(geom.row_off);
			push_entry.last = 1'b0;
		end else begin
			push_entry.kind = KIND_PIXEL;
			push_entry.a = (action_s1 == ACT_TICK) ? color_q : color_s1;
			push_entry.last = (left_q == LEFT_W'(1));
		end
	end

	// Hold the accepted item until it can move on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			action_s1 <= item.action;
			x_s1 <= COORD_W'(xc_w);
			y_s1 <= COORD_W'(yc_w);
			w_s1 <= SIZE_W'(wc_w);
			h_s1 <= SIZE_W'(hc_w);
			color_s1 <= to565(item.red, item.green, item.blue);
		end
	end

	// Update fill mode, color and pixel count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			color_q <= '0;
			left_q <= '0;
		end else if (adv && is_start) begin
			left_q <= LEFT_W'(area);
			if (action_s1 == ACT_SOLID_START) begin
				mode_q <= MODE_SOLID;
				color_q <= color_s1;
			end else begin
				mode_q <= MODE_IMAGE;
			end
		end else if (adv && pix_ok) begin
			left_q <= left_q - LEFT_W'(1);
			if (left_q == LEFT_W'(1)) begin
				mode_q <= MODE_IDLE;
			end
		end
	end

endmodule

### rtl/lrfs_back.sv
// Back end: pops queued jobs and emits one command or data byte per cycle
// when not stalled, via a registered result stage. Depends on lrfs_pkg.
module lrfs_back (
	input logic clk,
	input logic arst_n,
	input logic q_empty,
	input lrfs_pkg::entry_t head,
	output logic pop,
	input lrfs_pkg::ops_t ops,
	output logic result_valid,
	input logic result_stall,
	output lrfs_pkg::result_t result
);
	import lrfs_pkg::*;

	localparam logic [3:0] IDX_COL_OP = 4'd0;
	localparam logic [3:0] IDX_X0_HI = 4'd1;
	localparam logic [3:0] IDX_X0_LO = 4'd2;
	localparam logic [3:0] IDX_X1_HI = 4'd3;
	localparam logic [3:0] IDX_X1_LO = 4'd4;
	localparam logic [3:0] IDX_ROW_OP = 4'd5;
	localparam logic [3:0] IDX_Y0_HI = 4'd6;
	localparam logic [3:0] IDX_Y0_LO = 4'd7;
	localparam logic [3:0] IDX_Y1_HI = 4'd8;
	localparam logic [3:0] IDX_Y1_LO = 4'd9;
	localparam logic [3:0] IDX_MEM_OP = 4'd10;
	localparam logic [3:0] IDX_PIX_LO = 4'd1;

	logic [3:0] idx_q;
	logic out_valid_q;
	result_t out_q;
	logic can_load, take, final_byte;
	result_t sel;

	assign can_load = !out_valid_q || !result_stall;
	assign take = can_load && !q_empty;
	assign final_byte = (head.kind == KIND_START) ? (idx_q == IDX_MEM_OP) :
		(idx_q == IDX_PIX_LO);
	assign pop = take && final_byte;
	assign result_valid = out_valid_q;
	assign result = out_q;

	// Pick the byte for the current position in the job
	always_comb begin
		sel = '0;
		if (head.kind == KIND_PIXEL) begin
			sel.is_data = 1'b1;
			if (idx_q == IDX_PIX_LO) begin
				sel.out_byte = head.a[7:0];
				sel.last = head.last;
			end else begin
				sel.out_byte = head.a[15:8];
			end
		end else begin
			sel.is_data = 1'b1;
			case (idx_q)
				IDX_COL_OP: begin
					sel.out_byte = ops.col_op;
					sel.is_data = 1'b0;
				end
				IDX_X0_HI: sel.out_byte = head.a[15:8];
				IDX_X0_LO: sel.out_byte = head.a[7:0];
				IDX_X1_HI: sel.out_byte = head.b[15:8];
				IDX_X1_LO: sel.out_byte = head.b[7:0];
				IDX_ROW_OP: begin
					sel.out_byte = ops.row_op;
					sel.is_data = 1'b0;
				end
				IDX_Y0_HI: sel.out_byte = head.c[15:8];
				IDX_Y0_LO: sel.out_byte = head.c[7:0];
				IDX_Y1_HI: sel.out_byte = head.d[15:8];
				IDX_Y1_LO: sel.out_byte = head.d[7:0];
				default: begin
					sel.out_byte = ops.mem_op;
					sel.is_data = 1'b0;
				end
			endcase
		end
	end

	// Advance the byte position and load the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				idx_q <= final_byte ? 4'd0 : idx_q + 4'd1;
				out_valid_q <= 1'b1;
			end else if (can_load) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= sel;
		end
	end

endmodule

### rtl/lcd_rectangle_fill_stream.sv
// Top level of the LCD rectangle fill stream: config registers, front end,
// job queue and byte emitter. Depends on lrfs_pkg, lrfs_front, lrfs_queue,
// lrfs_back.
//
// Usage:
//   item channel (item_valid / item_stall / item): start-solid, start-image,
//   image pixel and solid tick items. result channel (result_valid /
//   result_stall / result): command and data bytes with is_data and last.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register
//   writes, always ready; write only while the block is idle.
// Path: an item passes the hold register, job queue and result register.
// Throughput: a pixel or tick yields two bytes; a start yields 11 bytes. The
// byte emitter, one byte per cycle into the result register while the
// receiver does not stall, sets the rate; a 4-entry job queue lets the front
// end take items while bytes drain. Items that match no active fill are
// dropped without a queued job.
// Reset: registers return to 240x240, zero offsets, opcodes 0x2A/0x2B/0x2C;
// no fill is active and the queue is empty.
// Receiver stall: the result holds; once the queue fills, item_stall rises.
module lcd_rectangle_fill_stream (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input lrfs_pkg::item_t item,
	output logic result_valid,
	input logic result_stall,
	output lrfs_pkg::result_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [lrfs_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [lrfs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lrfs_pkg::*;

	logic [SIZE_W-1:0] screen_w_q;
	logic [SIZE_W-1:0] screen_h_q;
	logic [9:0] col_off_q;
	logic [9:0] row_off_q;
	logic [7:0] col_op_q;
	logic [7:0] row_op_q;
	logic [7:0] mem_op_q;

	geom_t geom;
	ops_t ops;
	logic push, pop, q_full, q_empty;
	entry_t push_entry, head;

	assign cfg_ready = 1'b1;
	assign geom = '{screen_w: screen_w_q, screen_h: screen_h_q,
		col_off: col_off_q, row_off: row_off_q};
	assign ops = '{col_op: col_op_q, row_op: row_op_q, mem_op: mem_op_q};

	// Hold config; screen sizes are kept already clamped to 1..MAX_SIDE
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_w_q <= eff_size(RST_SCREEN_WIDTH);
			screen_h_q <= eff_size(RST_SCREEN_HEIGHT);
			col_off_q <= RST_COLUMN_OFFSET;
			row_off_q <= RST_ROW_OFFSET;
			col_op_q <= RST_COLUMN_SET_OPCODE;
			row_op_q <= RST_ROW_SET_OPCODE;
			mem_op_q <= RST_MEMORY_WRITE_OPCODE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SCREEN_WIDTH: screen_w_q <= eff_size(cfg_data[10:0]);
				CFG_SCREEN_HEIGHT: screen_h_q <= eff_size(cfg_data[10:0]);
				CFG_COLUMN_OFFSET: col_off_q <= cfg_data[9:0];
				CFG_ROW_OFFSET: row_off_q <= cfg_data[9:0];
				CFG_COLUMN_SET_OPCODE: col_op_q <= cfg_data[7:0];
				CFG_ROW_SET_OPCODE: row_op_q <= cfg_data[7:0];
				CFG_MEMORY_WRITE_OPCODE: mem_op_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	lrfs_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.geom(geom),
		.q_full(q_full),
		.push(push),
		.push_entry(push_entry)
	);

	lrfs_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_entry(push_entry),
		.pop(pop),
		.head(head),
		.full(q_full),
		.empty(q_empty)
	);

	lrfs_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.head(head),
		.pop(pop),
		.ops(ops),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

`ifndef ASSERT_OFF
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("job pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("job popped from an empty queue");

	a_last_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last) |-> result.is_data)
		else $error("last marked on a command byte");

	a_last_pops: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.kind == KIND_PIXEL && head.last) |=> (result_valid && result.last))
		else $error("final pixel byte not marked last");
`endif

endmodule
